// ===== src/pwl_pkg.sv =====
// Shared types and constants for the piecewise-linear table interpolator.
// Used by pwl_lookup, pwl_div, piecewise_linear_table_interp and its checker.
// No dependencies.
`default_nettype none

package pwl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Quotient width of the interpolation divide (one bit per stage)
  localparam int DIV_STEPS   = 32;

  // Input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Segment picked for one query
  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] clamp;
    status_t            status;
  } seg_t;

  // Data riding alongside the divider
  typedef struct packed {
    logic signed [31:0] v1;
    logic signed [31:0] clamp;
    logic               neg;
    status_t            status;
  } side_t;

endpackage

`default_nettype wire

// ===== src/piecewise_linear_table_interp.sv =====
// Top level: input stage, table lookup, segment differences, multiply, divide and output register.
// Depends on pwl_pkg, pwl_lookup and pwl_div.
//
//   channel   direction   handshake            payload
//   in_       in          in_valid / in_stall  command, entry_index, temperature, entry_value
//   out_      out         out_valid/ out_stall result_value, status
//   cfg_      in          cfg_we               cfg_wdata (entries_in_use)
//
// One item enters per cycle while in_stall is low; a query passes 38 register stages
// (the 32 one-bit divider stages plus six others) on its way to out_valid.
// Loads produce no result and update the table in order with queries.
// A stalled full output register freezes the whole pipeline; nothing is lost.
// Synchronous reset empties the pipeline and clears the entry count.
`default_nettype none

module piecewise_linear_table_interp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [3:0]         in_entry_index,
  input  wire logic signed [31:0] in_temperature,
  input  wire logic signed [31:0] in_entry_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic [1:0]              out_status,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata
);

  logic adv;
  logic out_valid_r;

  // Pipeline moves whenever the output register can take a result
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Configuration register
  logic [4:0] entries_in_use_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
    end else if (cfg_we) begin
      entries_in_use_r <= cfg_wdata;
    end
  end

  // Stage 1: input register
  logic               s1_v_r;
  logic               s1_cmd_r;
  logic [3:0]         s1_idx_r;
  logic signed [31:0] s1_t_r;
  logic signed [31:0] s1_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= in_command;
      s1_idx_r <= in_entry_index;
      s1_t_r   <= in_temperature;
      s1_val_r <= in_entry_value;
    end
  end

  // Stages 2 and 3: table compare and segment select
  logic          s3_v;
  pwl_pkg::seg_t s3_seg;

  pwl_lookup u_lookup (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .s1_valid       (s1_v_r),
    .s1_cmd         (s1_cmd_r),
    .s1_idx         (s1_idx_r),
    .s1_temp        (s1_t_r),
    .s1_value       (s1_val_r),
    .entries_in_use (entries_in_use_r),
    .s3_valid       (s3_v),
    .s3_seg         (s3_seg)
  );

  // Stage 4: differences and magnitude of the value step
  logic signed [32:0] dt_full;
  logic signed [32:0] dtt_full;
  logic signed [32:0] dv_full;
  logic [32:0]        dv_mag;

  assign dt_full  = 33'(s3_seg.t)  - 33'(s3_seg.t1);
  assign dtt_full = 33'(s3_seg.t2) - 33'(s3_seg.t1);
  assign dv_full  = 33'(s3_seg.v2) - 33'(s3_seg.v1);
  assign dv_mag   = dv_full[32] ? 33'(-dv_full) : 33'(dv_full);

  logic           s4_v_r;
  logic [31:0]    s4_dt_r;
  logic [31:0]    s4_dtt_r;
  logic [31:0]    s4_mag_r;
  pwl_pkg::side_t s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dt_r          <= dt_full[31:0];
      s4_dtt_r         <= dtt_full[31:0];
      s4_mag_r         <= dv_mag[31:0];
      s4_side_r.v1     <= s3_seg.v1;
      s4_side_r.clamp  <= s3_seg.clamp;
      s4_side_r.neg    <= dv_full[32];
      s4_side_r.status <= s3_seg.status;
    end
  end

  // Stage 5: product of value step and temperature offset
  logic           s5_v_r;
  logic [63:0]    s5_prod_r;
  logic [31:0]    s5_dtt_r;
  pwl_pkg::side_t s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_prod_r <= 64'(s4_mag_r) * 64'(s4_dt_r);
      s5_dtt_r  <= s4_dtt_r;
      s5_side_r <= s4_side_r;
    end
  end

  // Divide by the segment width
  logic           dq_v;
  logic [31:0]    dq;
  pwl_pkg::side_t dq_side;

  pwl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (s5_v_r),
    .dividend (s5_prod_r),
    .divisor  (s5_dtt_r),
    .in_side  (s5_side_r),
    .out_v    (dq_v),
    .quotient (dq),
    .out_side (dq_side)
  );

  // Output register: apply sign of the step, or take the clamp value
  logic signed [31:0] res_nxt;
  always_comb begin
    if (dq_side.status == pwl_pkg::ST_INTERP) begin
      res_nxt = dq_side.neg ? (dq_side.v1 - $signed(dq)) : (dq_side.v1 + $signed(dq));
    end else begin
      res_nxt = dq_side.clamp;
    end
  end

  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= res_nxt;
      out_status_r <= dq_side.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

// ===== src/pwl_lookup.sv =====
// Breakpoint storage, range compare and segment select (two pipeline stages).
// Depends on pwl_pkg.
`default_nettype none

module pwl_lookup (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                s1_valid,
  input  wire logic                s1_cmd,
  input  wire logic [3:0]          s1_idx,
  input  wire logic signed [31:0]  s1_temp,
  input  wire logic signed [31:0]  s1_value,
  input  wire logic [4:0]          entries_in_use,
  output logic                     s3_valid,
  output pwl_pkg::seg_t            s3_seg
);

  localparam int TD = pwl_pkg::TABLE_DEPTH;

  logic signed [31:0] tab_t_r [TD];
  logic signed [31:0] tab_v_r [TD];

  // Load write: done as the load leaves stage 1, in order with queries
  logic                     idx_ok;
  logic [pwl_pkg::IDX_W-1:0] slot;
  assign idx_ok = (32'(s1_idx) < 32'(TD));
  assign slot   = pwl_pkg::IDX_W'(s1_idx);

  always_ff @(posedge clk) begin
    if (adv && s1_valid && (s1_cmd == pwl_pkg::CMD_LOAD) && idx_ok) begin
      tab_t_r[slot] <= s1_temp;
      tab_v_r[slot] <= s1_value;
    end
  end

  // Stage 1: saturate count, compare query against the breakpoints in use
  logic [pwl_pkg::CNT_W-1:0] n_sat;
  logic [pwl_pkg::IDX_W-1:0] last_idx;
  logic [TD-1:0]             ge;
  pwl_pkg::status_t          st;
  logic signed [31:0]        clamp;

  assign n_sat    = (32'(entries_in_use) > 32'(TD)) ? pwl_pkg::CNT_W'(TD)
                                                    : pwl_pkg::CNT_W'(entries_in_use);
  assign last_idx = pwl_pkg::IDX_W'(n_sat - 1'b1);

  always_comb begin
    ge = '0;
    for (int i = 1; i < TD; i++) begin
      ge[i] = (tab_t_r[i] >= s1_temp) && (32'(i) < 32'(n_sat));
    end
  end

  always_comb begin
    if (n_sat == '0) begin
      st    = pwl_pkg::ST_EMPTY;
      clamp = '0;
    end else if (s1_temp <= tab_t_r[0]) begin
      st    = pwl_pkg::ST_BELOW;
      clamp = tab_v_r[0];
    end else if (s1_temp > tab_t_r[last_idx]) begin
      st    = pwl_pkg::ST_ABOVE;
      clamp = tab_v_r[last_idx];
    end else begin
      st    = pwl_pkg::ST_INTERP;
      clamp = '0;
    end
  end

  logic                s2_v_r;
  logic signed [31:0]  s2_t_r;
  logic [TD-1:0]       s2_ge_r;
  pwl_pkg::status_t    s2_st_r;
  logic signed [31:0]  s2_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_valid && (s1_cmd == pwl_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_t_r     <= s1_temp;
      s2_ge_r    <= ge;
      s2_st_r    <= st;
      s2_clamp_r <= clamp;
    end
  end

  // Stage 2: first qualifying slot and its predecessor
  logic [TD-1:0]      first;
  pwl_pkg::seg_t      seg_nxt;

  assign first = s2_ge_r & (~s2_ge_r + 1'b1);

  always_comb begin
    seg_nxt        = '0;
    seg_nxt.t      = s2_t_r;
    seg_nxt.clamp  = s2_clamp_r;
    seg_nxt.status = s2_st_r;
    for (int i = 0; i < TD; i++) begin
      if (first[i]) begin
        seg_nxt.t2 = seg_nxt.t2 | tab_t_r[i];
        seg_nxt.v2 = seg_nxt.v2 | tab_v_r[i];
      end
      if ((i + 1 < TD) && first[(i + 1) % TD]) begin
        seg_nxt.t1 = seg_nxt.t1 | tab_t_r[i];
        seg_nxt.v1 = seg_nxt.v1 | tab_v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_seg <= seg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/pwl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pwl_pkg.
`default_nettype none

module pwl_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_v,
  input  wire logic [63:0]         dividend,
  input  wire logic [31:0]         divisor,
  input  wire pwl_pkg::side_t      in_side,
  output logic                     out_v,
  output logic [31:0]              quotient,
  output pwl_pkg::side_t           out_side
);

  localparam int N = pwl_pkg::DIV_STEPS;

  logic [63:0]    acc_r  [N];
  logic [31:0]    dvs_r  [N];
  pwl_pkg::side_t side_r [N];
  logic [N-1:0]   v_r;

  logic [63:0]    acc_in  [N];
  logic [31:0]    dvs_in  [N];
  pwl_pkg::side_t side_in [N];
  logic [63:0]    acc_nxt [N];

  // Stage inputs: previous stage or the entry port
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        acc_in[k]  = dividend;
        dvs_in[k]  = divisor;
        side_in[k] = in_side;
      end else begin
        acc_in[k]  = acc_r[(k + N - 1) % N];
        dvs_in[k]  = dvs_r[(k + N - 1) % N];
        side_in[k] = side_r[(k + N - 1) % N];
      end
    end
  end

  // One shift, compare and subtract per stage; quotient bits fill from the bottom
  always_comb begin
    logic [32:0] top;
    logic [32:0] diff;
    logic        take;
    for (int k = 0; k < N; k++) begin
      top        = acc_in[k][63:31];
      diff       = top - {1'b0, dvs_in[k]};
      take       = (top >= {1'b0, dvs_in[k]});
      acc_nxt[k] = {(take ? diff[31:0] : top[31:0]), acc_in[k][30:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        acc_r[k]  <= acc_nxt[k];
        dvs_r[k]  <= dvs_in[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign out_v    = v_r[N-1];
  assign quotient = acc_r[N-1][31:0];
  assign out_side = side_r[N-1];

endmodule

`default_nettype wire

// ===== src/pwl_checker.sv =====
// Port-level checker for piecewise_linear_table_interp, bound to the top level.
// Depends on pwl_pkg.
`default_nettype none

module pwl_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_result_value,
  input wire logic [1:0]         out_status
);

  // Held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_status))
    else $error("stalled result changed");

  // Input backpressure only when the output is full and stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match output state");

  // Empty-table result is zero
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 2'(pwl_pkg::ST_EMPTY)) |-> out_result_value == 32'sd0)
    else $error("empty-table result not zero");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind piecewise_linear_table_interp pwl_checker u_pwl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);

`default_nettype wire
